// ===== hdl/smsa_pkg.sv =====
// shared constants and types for the sliding median spike alert block
package smsa_pkg;

  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 9;
  localparam int COUNT_W         = 32;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REMOVE,
    PH_INSERT
  } phase_t;

  // operation broadcast to every sorted cell in the same cycle
  typedef struct packed {
    logic rem;
    logic ins;
  } cell_cmd_t;

endpackage

// ===== hdl/smsa_ifs.sv =====
// valid/ready channel interfaces for samples, results and configuration
interface smsa_in_if #(
  parameter int DATA_W = smsa_pkg::SAMPLE_BITS_DEF
);
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface smsa_out_if;
  logic                        valid;
  logic                        ready;
  logic                        window_full;
  logic                        alert;
  logic [smsa_pkg::COUNT_W-1:0] alert_count;

  modport source (output valid, output window_full, output alert, output alert_count,
                  input ready);
  modport sink (input valid, input window_full, input alert, input alert_count,
                output ready);
endinterface

interface smsa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [smsa_pkg::CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/smsa_ram.sv =====
// generic simple dual port ram with registered read
module smsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/smsa_cell.sv =====
// one position of the sorted store, shifting with its neighbors on remove and insert
module smsa_cell #(
  parameter int SAMPLE_BITS = smsa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  smsa_pkg::cell_cmd_t    cmd,
  input  logic [SAMPLE_BITS-1:0] key,
  input  logic                   occupied,
  input  logic [SAMPLE_BITS-1:0] left_val,
  input  logic                   left_gt,
  input  logic [SAMPLE_BITS-1:0] right_val,
  output logic [SAMPLE_BITS-1:0] val,
  output logic                   gt
);

  logic [SAMPLE_BITS-1:0] val_next;

  // empty positions count as larger than any key
  assign gt = !occupied || (val > key);

  always_comb begin
    val_next = val;
    if (cmd.rem) begin
      // in sorted order the first copy of key is the first cell >= key
      if (val >= key) begin
        val_next = right_val;
      end
    end else if (cmd.ins) begin
      if (gt) begin
        val_next = left_gt ? left_val : key;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== hdl/sliding_median_spike_alert.sv =====
// top level of the sliding window median spike alert block
//
// samples: one unsigned sample per transaction. results: one transaction per
// sample with window_full, alert and the saturating alert_count. cfg: writes
// the window length; zero acts as one, values above WINDOW_MAX clamp to it.
// A cfg write empties the window and keeps the alert count; cfg is always ready
// and is meant to be written only while no sample is in flight.
// Each sample takes a remove step, then an insert step, in the sorted cells:
// remove reads the oldest sample from the arrival ring (registered read
// issued at accept), runs the median test and, if the window is full, shifts
// that sample out; insert shifts the new sample in. The result is registered
// in the remove step, and a new sample may be accepted in the insert step of
// the one before. The output register holds a result while the receiver
// stalls; the next sample is still accepted, and its remove step waits until
// the output register is free, so samples then stall too.
// Reset empties the window, sets the length to one and clears the alert count.
// The arrival ring and sorted cells hold no reset values; the fill count
// decides which entries are live.
module sliding_median_spike_alert #(
  parameter int WINDOW_MAX  = smsa_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = smsa_pkg::SAMPLE_BITS_DEF
) (
  input logic   clk,
  input logic   rst,
  smsa_in_if.sink    samples,
  smsa_out_if.source results,
  smsa_cfg_if.sink   cfg
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  smsa_pkg::phase_t    phase, phase_next;
  smsa_pkg::cell_cmd_t cmd;

  logic [LEN_W-1:0]   len, mid, mid_lo, len_cfg;
  logic [LEN_W-1:0]   fill;
  logic [PTR_W-1:0]   ptr;
  logic [LEN_W:0]     ptr_inc;
  logic [smsa_pkg::COUNT_W-1:0] alert_total;

  logic [SAMPLE_BITS-1:0] s_rem, s_ins, old_sample, key;
  logic [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cell_gt;
  logic [SAMPLE_BITS-1:0] med_hi, med_lo;
  logic [SAMPLE_BITS:0]   med_ref;

  logic accept, out_free, rem_go, full, spike;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (phase != smsa_pkg::PH_REMOVE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;
  assign rem_go        = (phase == smsa_pkg::PH_REMOVE) && out_free;
  assign full          = (fill >= len);

  always_comb begin
    if (32'(cfg.data) > 32'(WINDOW_MAX)) begin
      len_cfg = LEN_W'(WINDOW_MAX);
    end else if (cfg.data == '0) begin
      len_cfg = LEN_W'(1);
    end else begin
      len_cfg = LEN_W'(cfg.data);
    end
  end

  always_comb begin
    phase_next = smsa_pkg::PH_IDLE;
    case (phase)
      smsa_pkg::PH_IDLE:   phase_next = accept ? smsa_pkg::PH_REMOVE : smsa_pkg::PH_IDLE;
      smsa_pkg::PH_REMOVE: phase_next = out_free ? smsa_pkg::PH_INSERT : smsa_pkg::PH_REMOVE;
      smsa_pkg::PH_INSERT: phase_next = accept ? smsa_pkg::PH_REMOVE : smsa_pkg::PH_IDLE;
      default:             phase_next = smsa_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= smsa_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // arrival ring: oldest sample is read at accept, overwritten in the remove cycle
  smsa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (rem_go),
    .waddr (ptr),
    .wdata (s_rem),
    .re    (accept),
    .raddr (ptr),
    .rdata (old_sample)
  );

  assign cmd.rem = rem_go && full;
  assign cmd.ins = (phase == smsa_pkg::PH_INSERT);
  assign key     = (phase == smsa_pkg::PH_INSERT) ? s_ins : old_sample;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv, rv;
    logic                   lg;
    if (g == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[g-1];
      assign lg = cell_gt[g-1];
    end
    if (g == WINDOW_MAX - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = cell_val[g+1];
    end
    smsa_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key),
      .occupied  (LEN_W'(g) < fill),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .val       (cell_val[g]),
      .gt        (cell_gt[g])
    );
  end

  // median taps; for odd length both taps select the middle cell
  always_comb begin
    med_hi = '0;
    med_lo = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (LEN_W'(i) == mid) begin
        med_hi = cell_val[i];
      end
      if (LEN_W'(i) == mid_lo) begin
        med_lo = cell_val[i];
      end
    end
  end

  assign med_ref = {1'b0, med_hi} + {1'b0, med_lo};
  assign spike   = full && ({1'b0, s_rem} >= med_ref);
  assign ptr_inc = (LEN_W + 1)'(ptr) + (LEN_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= LEN_W'(1);
      mid         <= '0;
      mid_lo      <= '0;
      fill        <= '0;
      ptr         <= '0;
      alert_total <= '0;
    end else if (cfg.valid) begin
      len    <= len_cfg;
      mid    <= len_cfg >> 1;
      mid_lo <= len_cfg[0] ? (len_cfg >> 1) : ((len_cfg >> 1) - LEN_W'(1));
      fill   <= '0;
      ptr    <= '0;
    end else begin
      if (rem_go) begin
        ptr <= (ptr_inc >= (LEN_W + 1)'(len)) ? '0 : ptr_inc[PTR_W-1:0];
        if (full) begin
          fill <= fill - LEN_W'(1);
        end
        if (spike && (alert_total != '1)) begin
          alert_total <= alert_total + smsa_pkg::COUNT_W'(1);
        end
      end else if (phase == smsa_pkg::PH_INSERT) begin
        fill <= fill + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_rem <= samples.sample;
    end
    if (rem_go) begin
      s_ins <= s_rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (rem_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rem_go) begin
      results.window_full <= full;
      results.alert       <= spike;
      results.alert_count <= (spike && (alert_total != '1))
                             ? alert_total + smsa_pkg::COUNT_W'(1) : alert_total;
    end
  end

endmodule
